// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers; clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/core/tssu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tssu_pkg;

    localparam int ID_BITS = 7;

    localparam logic [2:0] OP_CREATE      = 3'd0;
    localparam logic [2:0] OP_EXIT        = 3'd1;
    localparam logic [2:0] OP_JOIN        = 3'd2;
    localparam logic [2:0] OP_TICK        = 3'd3;
    localparam logic [2:0] OP_SEM_SETUP   = 3'd4;
    localparam logic [2:0] OP_SEM_WAIT    = 3'd5;
    localparam logic [2:0] OP_SEM_POST    = 3'd6;
    localparam logic [2:0] OP_SEM_DESTROY = 3'd7;

    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_NOSLOT    = 3'd1;
    localparam logic [2:0] RC_WAITERS   = 3'd2;
    localparam logic [2:0] RC_NOINIT    = 3'd3;
    localparam logic [2:0] RC_REFUSED   = 3'd4;
    localparam logic [2:0] RC_NONEREADY = 3'd5;

    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_EXITED  = 2'd3;

    typedef struct packed {
        logic [2:0]         code;
        logic [ID_BITS-1:0] new_id;
        logic [ID_BITS-1:0] running;
        logic               acquired;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/tssu_result_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tssu_result_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire tssu_pkg::result_t res,
    output logic                   can_load,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             result_code,
    output logic [6:0]             new_id,
    output logic [6:0]             running_thread,
    output logic                   acquired
);
    import tssu_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // a held word frees the register in the same cycle it is taken
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        if (load && can_load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid      = valid_reg;
    assign result_code    = data_reg.code;
    assign new_id         = data_reg.new_id;
    assign running_thread = data_reg.running;
    assign acquired       = data_reg.acquired;

endmodule

`default_nettype wire

// ----- rtl/core/thread_scheduler_semaphore_unit.sv -----
// Thread-state and counting-semaphore unit with a round-robin scheduler.
// Input channel: in_valid / in_stall carry one command word (opcode,
// target_id, init_value). Output channel: out_valid / out_stall carry one
// result word per command (result_code, new_id, running_thread, acquired).
// Commands are handled one at a time; the next word is taken the cycle after
// the result is loaded. Each table has a single read port.
// Semaphore post and destroy, and a wait that does not block, read the
// semaphore entry and then load the result; a bad index skips the read, and
// a post that wakes a waiter also reads the wait-list link and the waiter.
// exit, tick, a create that finds a slot, a join that blocks and a blocking
// wait end in a reschedule sweep over all NUM_THREADS entries, one
// thread-table read per cycle. create first walks slots 1 to NUM_THREADS-1
// for a free one; semaphore setup walks the same way.
// After reset the unit clears the thread and semaphore tables, one entry per
// cycle, with in_stall high; then it takes commands.
// The result sits in an output register: a stalled receiver holds it while
// the next command is taken and worked on; the unit waits at the end of
// that command until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module thread_scheduler_semaphore_unit #(
    parameter int NUM_THREADS = 128,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [6:0]  target_id,
    input  wire logic [15:0] init_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       result_code,
    output logic [6:0]       new_id,
    output logic [6:0]       running_thread,
    output logic             acquired
);
    import tssu_pkg::*;

    localparam int TW = $clog2(NUM_THREADS);
    localparam int CW = $clog2(NUM_THREADS + 1);
    localparam logic [31:0] CMAX32 = 32'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_CRE_Z0   = 4'd4;
    localparam logic [3:0] S_EXIT_A   = 4'd5;
    localparam logic [3:0] S_EXIT_J   = 4'd6;
    localparam logic [3:0] S_JOIN_T   = 4'd7;
    localparam logic [3:0] S_JOIN_C   = 4'd8;
    localparam logic [3:0] S_JOIN_W   = 4'd9;
    localparam logic [3:0] S_SEM_R    = 4'd10;
    localparam logic [3:0] S_WAIT_C   = 4'd11;
    localparam logic [3:0] S_POST_J   = 4'd12;
    localparam logic [3:0] S_RESCHED  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    typedef struct packed {
        logic [1:0]    state;
        logic [1:0]    saved;
        logic          busy;
        logic          jvalid;
        logic [TW-1:0] jidx;
    } thr_word_t;

    typedef struct packed {
        logic                  in_use;
        logic [COUNT_BITS-1:0] count;
        logic [TW-1:0]         head;
        logic [TW-1:0]         tail;
        logic [CW-1:0]         len;
    } sem_word_t;

    thr_word_t     thr_mem [NUM_THREADS];
    sem_word_t     sem_mem [NUM_THREADS];
    logic [TW-1:0] lnk_mem [NUM_THREADS];

    thr_word_t     thr_rd_reg;
    sem_word_t     sem_rd_reg;
    logic [TW-1:0] lnk_rd_reg;

    logic          thr_we, sem_we, lnk_we;
    logic [TW-1:0] thr_waddr, thr_raddr, sem_waddr, sem_raddr, lnk_waddr, lnk_raddr;
    thr_word_t     thr_wdata;
    sem_word_t     sem_wdata;
    logic [TW-1:0] lnk_wdata;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [6:0]    tid_reg, tid_next;
    logic [15:0]   iv_reg, iv_next;
    logic [2:0]    code_reg, code_next;
    logic [6:0]    nid_reg, nid_next;
    logic          acq_reg, acq_next;
    logic [TW-1:0] cur_reg, cur_next;
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] addr_reg, addr_next;
    logic          pend_reg, pend_next;
    logic [TW-1:0] paddr_reg, paddr_next;
    logic          found_reg, found_next;
    logic [TW-1:0] pick_reg, pick_next;
    thr_word_t     sav_word_reg, sav_word_next;
    sem_word_t     sem_word_reg, sem_word_next;

    logic                  res_load, res_can_load;
    result_t               res;
    logic [TW-1:0]         tidx;
    logic                  tid_ok;
    logic [COUNT_BITS-1:0] init_cnt;
    logic [COUNT_BITS-1:0] cnt_max;
    logic [TW-1:0]         cur_inc;

    assign tidx     = TW'(tid_reg);
    assign tid_ok   = ({25'd0, tid_reg} < 32'(NUM_THREADS));
    assign cnt_max  = CMAX32[COUNT_BITS-1:0];
    assign init_cnt = (32'(iv_reg) > CMAX32) ? cnt_max : COUNT_BITS'(iv_reg);
    assign cur_inc  = (cur_reg == TW'(NUM_THREADS - 1)) ? '0 : cur_reg + TW'(1);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        thr_word_t     tw;
        sem_word_t     sw;
        logic [CW-1:0] l1;
        logic          rs_start;

        state_next    = state_reg;
        op_next       = op_reg;
        tid_next      = tid_reg;
        iv_next       = iv_reg;
        code_next     = code_reg;
        nid_next      = nid_reg;
        acq_next      = acq_reg;
        cur_next      = cur_reg;
        live_next     = live_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        pend_next     = pend_reg;
        paddr_next    = paddr_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        sav_word_next = sav_word_reg;
        sem_word_next = sem_word_reg;
        thr_we        = 1'b0;
        thr_waddr     = paddr_reg;
        thr_wdata     = thr_rd_reg;
        thr_raddr     = addr_reg;
        sem_we        = 1'b0;
        sem_waddr     = tidx;
        sem_wdata     = sem_word_reg;
        sem_raddr     = tidx;
        lnk_we        = 1'b0;
        lnk_waddr     = sem_word_reg.tail;
        lnk_wdata     = cur_reg;
        lnk_raddr     = sem_word_reg.head;
        res_load      = 1'b0;
        rs_start      = 1'b0;
        tw            = thr_rd_reg;
        sw            = sem_rd_reg;
        l1 = (live_reg < CW'(NUM_THREADS)) ? live_reg + CW'(1) : live_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                thr_we    = 1'b1;
                thr_waddr = cnt_reg[TW-1:0];
                thr_wdata = '0;
                sem_we    = 1'b1;
                sem_waddr = cnt_reg[TW-1:0];
                sem_wdata = '0;
                if (cnt_reg == CW'(NUM_THREADS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    tid_next   = target_id;
                    iv_next    = init_value;
                    code_next  = RC_OK;
                    nid_next   = '0;
                    acq_next   = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_CREATE, OP_SEM_SETUP:
                    begin
                        addr_next  = TW'(1);
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                    OP_EXIT:
                    begin
                        thr_raddr  = cur_reg;
                        state_next = S_EXIT_A;
                    end
                    OP_JOIN:
                    begin
                        if (!tid_ok || tidx == cur_reg)
                        begin
                            code_next  = RC_REFUSED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            thr_raddr  = tidx;
                            state_next = S_JOIN_T;
                        end
                    end
                    OP_TICK:
                    begin
                        rs_start = 1'b1;
                    end
                    default:
                    begin
                        if (!tid_ok)
                        begin
                            code_next  = RC_NOINIT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            sem_raddr  = tidx;
                            state_next = S_SEM_R;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                // lowest free slot from 1 upward, one entry per cycle
                pend_next = 1'b0;
                if (cnt_reg < CW'(NUM_THREADS - 1))
                begin
                    thr_raddr  = addr_reg;
                    sem_raddr  = addr_reg;
                    addr_next  = addr_reg + TW'(1);
                    cnt_next   = cnt_reg + CW'(1);
                    pend_next  = 1'b1;
                    paddr_next = addr_reg;
                end
                if (pend_reg)
                begin
                    if (op_reg == OP_CREATE && !thr_rd_reg.busy)
                    begin
                        pend_next        = 1'b0;
                        tw.state         = ST_READY;
                        tw.saved         = ST_UNUSED;
                        tw.busy          = 1'b1;
                        tw.jvalid        = 1'b0;
                        tw.jidx          = '0;
                        thr_we           = 1'b1;
                        thr_waddr        = paddr_reg;
                        thr_wdata        = tw;
                        nid_next         = 7'(paddr_reg);
                        live_next        = l1;
                        if (l1 == CW'(1))
                        begin
                            // first thread: thread 0 joins the ready set
                            live_next  = CW'(2);
                            thr_raddr  = '0;
                            state_next = S_CRE_Z0;
                        end
                        else
                        begin
                            rs_start = 1'b1;
                        end
                    end
                    else if (op_reg == OP_SEM_SETUP && !sem_rd_reg.in_use)
                    begin
                        pend_next  = 1'b0;
                        sw.in_use  = 1'b1;
                        sw.count   = init_cnt;
                        sw.head    = '0;
                        sw.tail    = '0;
                        sw.len     = '0;
                        sem_we     = 1'b1;
                        sem_waddr  = paddr_reg;
                        sem_wdata  = sw;
                        nid_next   = 7'(paddr_reg);
                        state_next = S_DONE;
                    end
                end
                else if (cnt_reg == CW'(NUM_THREADS - 1))
                begin
                    code_next  = RC_NOSLOT;
                    state_next = S_DONE;
                end
            end
            S_CRE_Z0:
            begin
                tw.state  = ST_READY;
                thr_we    = 1'b1;
                thr_waddr = '0;
                thr_wdata = tw;
                rs_start  = 1'b1;
            end
            S_EXIT_A:
            begin
                rs_start = 1'b1;
                if (tw.state == ST_READY)
                begin
                    thr_we    = 1'b1;
                    thr_waddr = cur_reg;
                    thr_wdata = tw;
                    thr_wdata.state  = ST_EXITED;
                    thr_wdata.busy   = 1'b0;
                    thr_wdata.jvalid = 1'b0;
                    thr_wdata.jidx   = '0;
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - CW'(1);
                    end
                    if (tw.jvalid)
                    begin
                        rs_start   = 1'b0;
                        thr_raddr  = tw.jidx;
                        paddr_next = tw.jidx;
                        state_next = S_EXIT_J;
                    end
                end
            end
            S_EXIT_J:
            begin
                if (tw.state == ST_BLOCKED)
                begin
                    tw.state  = tw.saved;
                    thr_we    = 1'b1;
                    thr_waddr = paddr_reg;
                    thr_wdata = tw;
                end
                rs_start = 1'b1;
            end
            S_JOIN_T:
            begin
                sav_word_next = tw;
                if (tw.jvalid)
                begin
                    code_next  = RC_REFUSED;
                    state_next = S_DONE;
                end
                else if (tw.state == ST_UNUSED || tw.state == ST_EXITED)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    thr_raddr  = cur_reg;
                    state_next = S_JOIN_C;
                end
            end
            S_JOIN_C:
            begin
                if (tw.state != ST_READY)
                begin
                    code_next  = RC_REFUSED;
                    state_next = S_DONE;
                end
                else
                begin
                    tw.saved   = tw.state;
                    tw.state   = ST_BLOCKED;
                    thr_we     = 1'b1;
                    thr_waddr  = cur_reg;
                    thr_wdata  = tw;
                    state_next = S_JOIN_W;
                end
            end
            S_JOIN_W:
            begin
                thr_we    = 1'b1;
                thr_waddr = tidx;
                thr_wdata = sav_word_reg;
                thr_wdata.jvalid = 1'b1;
                thr_wdata.jidx   = cur_reg;
                rs_start  = 1'b1;
            end
            S_SEM_R:
            begin
                sem_word_next = sw;
                state_next    = S_DONE;
                if (!sw.in_use)
                begin
                    code_next = RC_NOINIT;
                end
                else
                begin
                    unique case (op_reg)
                        OP_SEM_WAIT:
                        begin
                            if (sw.count != '0)
                            begin
                                sw.count  = sw.count - COUNT_BITS'(1);
                                sem_we    = 1'b1;
                                sem_wdata = sw;
                                acq_next  = 1'b1;
                            end
                            else
                            begin
                                thr_raddr  = cur_reg;
                                state_next = S_WAIT_C;
                            end
                        end
                        OP_SEM_POST:
                        begin
                            if (sw.len != '0)
                            begin
                                thr_raddr  = sw.head;
                                lnk_raddr  = sw.head;
                                state_next = S_POST_J;
                            end
                            else if (sw.count != cnt_max)
                            begin
                                sw.count  = sw.count + COUNT_BITS'(1);
                                sem_we    = 1'b1;
                                sem_wdata = sw;
                            end
                        end
                        OP_SEM_DESTROY:
                        begin
                            if (sw.len != '0)
                            begin
                                code_next = RC_WAITERS;
                            end
                            else
                            begin
                                sw.in_use = 1'b0;
                                sem_we    = 1'b1;
                                sem_wdata = sw;
                            end
                        end
                        default:
                        begin
                            code_next = RC_NOINIT;
                        end
                    endcase
                end
            end
            S_WAIT_C:
            begin
                sw = sem_word_reg;
                if (tw.state != ST_READY)
                begin
                    code_next  = RC_NONEREADY;
                    state_next = S_DONE;
                end
                else
                begin
                    // append caller to the FIFO linked through the thread slots
                    if (sw.len == '0)
                    begin
                        sw.head = cur_reg;
                    end
                    else
                    begin
                        lnk_we = 1'b1;
                    end
                    sw.tail   = cur_reg;
                    sw.len    = sw.len + CW'(1);
                    sem_we    = 1'b1;
                    sem_wdata = sw;
                    tw.saved  = tw.state;
                    tw.state  = ST_BLOCKED;
                    thr_we    = 1'b1;
                    thr_waddr = cur_reg;
                    thr_wdata = tw;
                    rs_start  = 1'b1;
                end
            end
            S_POST_J:
            begin
                sw = sem_word_reg;
                if (sw.len > CW'(1))
                begin
                    sw.head = lnk_rd_reg;
                end
                sw.len     = sw.len - CW'(1);
                sem_we     = 1'b1;
                sem_wdata  = sw;
                tw.state   = tw.saved;
                thr_we     = 1'b1;
                thr_waddr  = sem_word_reg.head;
                thr_wdata  = tw;
                state_next = S_DONE;
            end
            S_RESCHED:
            begin
                // full sweep from cur+1 round robin; reclaims exited slots when the
                // current thread is 0
                pend_next = 1'b0;
                if (cnt_reg < CW'(NUM_THREADS))
                begin
                    thr_raddr  = addr_reg;
                    addr_next  = (addr_reg == TW'(NUM_THREADS - 1)) ? '0
                                                                   : addr_reg + TW'(1);
                    cnt_next   = cnt_reg + CW'(1);
                    pend_next  = 1'b1;
                    paddr_next = addr_reg;
                end
                if (pend_reg)
                begin
                    if (cur_reg == '0 && tw.state == ST_EXITED)
                    begin
                        tw.state  = ST_UNUSED;
                        thr_we    = 1'b1;
                        thr_waddr = paddr_reg;
                        thr_wdata = tw;
                    end
                    if (thr_rd_reg.state == ST_READY && !found_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = paddr_reg;
                    end
                end
                else if (cnt_reg == CW'(NUM_THREADS))
                begin
                    if (found_reg)
                    begin
                        cur_next = pick_reg;
                    end
                    else
                    begin
                        code_next = RC_NONEREADY;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_load = 1'b1;
                if (res_can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rs_start)
        begin
            addr_next  = cur_inc;
            cnt_next   = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
            state_next = S_RESCHED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            live_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            live_reg  <= live_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tid_reg      <= tid_next;
        iv_reg       <= iv_next;
        code_reg     <= code_next;
        nid_reg      <= nid_next;
        acq_reg      <= acq_next;
        addr_reg     <= addr_next;
        paddr_reg    <= paddr_next;
        pick_reg     <= pick_next;
        sav_word_reg <= sav_word_next;
        sem_word_reg <= sem_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (thr_we)
        begin
            thr_mem[thr_waddr] <= thr_wdata;
        end
        thr_rd_reg <= thr_mem[thr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sem_we)
        begin
            sem_mem[sem_waddr] <= sem_wdata;
        end
        sem_rd_reg <= sem_mem[sem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        lnk_rd_reg <= lnk_mem[lnk_raddr];
    end

    assign res.code     = code_reg;
    assign res.new_id   = nid_reg;
    assign res.running  = 7'(cur_reg);
    assign res.acquired = acq_reg;

    tssu_result_reg u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (res_load),
        .res            (res),
        .can_load       (res_can_load),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_code    (result_code),
        .new_id         (new_id),
        .running_thread (running_thread),
        .acquired       (acquired)
    );

    `ASSERT_NEVER(a_live_range, live_reg > CW'(NUM_THREADS), "live count above thread count")
    `ASSERT_AT(a_accept_dispatch,
        (in_valid && !in_stall) |=> state_reg == S_DISPATCH,
        "accepted word not dispatched")
    `ASSERT_AT(a_pick_taken,
        (state_reg == S_RESCHED && !pend_reg && cnt_reg == CW'(NUM_THREADS) && found_reg)
            |=> cur_reg == $past(pick_reg),
        "picked thread not made current")

endmodule

`default_nettype wire
